[sv/scn_pkg.sv]
package scn_pkg;

  // frame modes, chosen at the first slot of a frame
  localparam logic [1:0] MODE_NUM = 2'd0;  // 0..9999
  localparam logic [1:0] MODE_NEG = 2'd1;  // -999..-1
  localparam logic [1:0] MODE_OVF = 2'd2;  // above 9999
  localparam logic [1:0] MODE_UNF = 2'd3;  // below -999

  localparam logic signed [31:0] VALUE_MAX = 32'sd9999;
  localparam logic signed [31:0] VALUE_MIN = -32'sd999;

  localparam logic [7:0] REPEATS_RESET = 8'd16;

  localparam logic [6:0] SEG_E     = 7'h79;
  localparam logic [6:0] SEG_R     = 7'h50;
  localparam logic [6:0] SEG_MINUS = 7'h40;

  typedef enum logic [1:0] {
    SYM_DIGIT,
    SYM_MINUS,
    SYM_E,
    SYM_R
  } sym_e;

  // one slot as classified by the front end
  typedef struct packed {
    sym_e        sym;
    logic [1:0]  rank;
    logic        frame_end;
    logic [13:0] mag;
  } scn_token_t;

  function automatic logic [6:0] seg_of_digit(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

[sv/scn_if.sv]
interface scn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

interface scn_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_enable;
  logic [6:0] segments;
  logic       frame_end;

  modport source (output valid, digit_enable, segments, frame_end, input ready);
  modport sink   (input valid, digit_enable, segments, frame_end, output ready);
endinterface

[sv/scn_front.sv]
module scn_front import scn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   frame_repeats_i,
  scn_in_if.sink       in_i,
  input  logic         full_i,
  output logic         push_o,
  output scn_token_t   token_o
);

  logic        active_q, active_d;
  logic [1:0]  mode_q, mode_d;
  logic [13:0] mag_q, mag_d;
  logic [1:0]  slot_q, slot_d;
  logic [7:0]  round_q, round_d;
  logic [1:0]  rnd3_q, rnd3_d;

  logic [1:0]  cur_mode, cur_slot, cur_r3;
  logic [7:0]  cur_round, rep;
  logic [13:0] cur_mag, new_mag;
  logic [1:0]  new_mode;
  logic [31:0] neg_value;
  logic        last_slot, last_round;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // classify a new value
  always_comb begin
    neg_value = 32'd0 - in_i.value;
    if (in_i.value > VALUE_MAX) begin
      new_mode = MODE_OVF;
      new_mag  = 14'd0;
    end else if (in_i.value < VALUE_MIN) begin
      new_mode = MODE_UNF;
      new_mag  = 14'd0;
    end else if (in_i.value[31]) begin
      new_mode = MODE_NEG;
      new_mag  = neg_value[13:0];
    end else begin
      new_mode = MODE_NUM;
      new_mag  = in_i.value[13:0];
    end
  end

  assign cur_mode  = active_q ? mode_q  : new_mode;
  assign cur_mag   = active_q ? mag_q   : new_mag;
  assign cur_slot  = active_q ? slot_q  : 2'd0;
  assign cur_round = active_q ? round_q : 8'd0;
  assign cur_r3    = active_q ? rnd3_q  : 2'd0;

  // rounds have mode+1 slots
  assign rep        = (cur_mode == MODE_UNF || frame_repeats_i == 8'd0) ? 8'd1
                                                                      : frame_repeats_i;
  assign last_slot  = cur_slot == cur_mode;
  assign last_round = ({1'b0, cur_round} + 9'd1) >= {1'b0, rep};

  always_comb begin
    token_o.mag       = cur_mag;
    token_o.frame_end = last_slot && last_round;
    token_o.sym       = SYM_DIGIT;
    token_o.rank      = 2'd0;
    unique case (cur_mode)
      MODE_NUM: begin
        token_o.rank = cur_round[1:0];
      end
      MODE_NEG: begin
        if (cur_slot == 2'd0) begin
          token_o.sym  = SYM_MINUS;
          token_o.rank = 2'd3;
        end else begin
          token_o.rank = cur_r3;
        end
      end
      MODE_OVF: begin
        token_o.rank = 2'd2 - cur_slot;
        token_o.sym  = (cur_slot == 2'd0) ? SYM_E : SYM_R;
      end
      default: begin
        token_o.rank = 2'd3 - cur_slot;
        case (cur_slot)
          2'd0:    token_o.sym = SYM_MINUS;
          2'd1:    token_o.sym = SYM_E;
          default: token_o.sym = SYM_R;
        endcase
      end
    endcase
  end

  always_comb begin
    active_d = active_q;
    mode_d   = mode_q;
    mag_d    = mag_q;
    slot_d   = slot_q;
    round_d  = round_q;
    rnd3_d   = rnd3_q;
    if (push_o) begin
      active_d = 1'b1;
      mode_d   = cur_mode;
      mag_d    = cur_mag;
      round_d  = cur_round;
      rnd3_d   = cur_r3;
      if (last_slot) begin
        slot_d = 2'd0;
        if (last_round) begin
          active_d = 1'b0;
          round_d  = 8'd0;
          rnd3_d   = 2'd0;
        end else begin
          round_d = cur_round + 8'd1;
          rnd3_d  = (cur_r3 == 2'd2) ? 2'd0 : cur_r3 + 2'd1;
        end
      end else begin
        slot_d = cur_slot + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      mode_q   <= MODE_NUM;
      slot_q   <= 2'd0;
      round_q  <= 8'd0;
      rnd3_q   <= 2'd0;
    end else begin
      active_q <= active_d;
      mode_q   <= mode_d;
      slot_q   <= slot_d;
      round_q  <= round_d;
      rnd3_q   <= rnd3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

endmodule

[sv/scn_fifo.sv]
module scn_fifo import scn_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  scn_token_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output scn_token_t data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  scn_token_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count lost a push");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

[sv/scn_back.sv]
module scn_back import scn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  scn_token_t token_i,
  output logic       pop_o,
  scn_out_if.source  out_o
);

  // three stages: /10 per stage, last stage also encodes
  logic       v1_q, v2_q, v3_q;
  logic       en1, en2, en3;
  scn_token_t t1_q, t2_q;
  logic [9:0] q1_q;
  logic [6:0] q2_q;
  logic [3:0] d0_q, d1_q, d0_2_q;

  logic [26:0] p1, p2, p3;
  logic [9:0]  q1;
  logic [6:0]  q2;
  logic [3:0]  q3;
  logic [13:0] r0;
  logic [9:0]  r1;
  logic [6:0]  r2;
  logic [3:0]  digit;
  logic [6:0]  seg;

  assign en3   = !v3_q || out_o.ready;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign pop_o = valid_i && en1;

  // x/10 as (x * 6554) >> 16, exact for x below 10000
  assign p1 = {13'd0, token_i.mag} * 27'd6554;
  assign q1 = p1[25:16];
  assign r0 = token_i.mag - ({4'd0, q1} * 14'd10);

  assign p2 = {17'd0, q1_q} * 27'd6554;
  assign q2 = p2[22:16];
  assign r1 = q1_q - ({3'd0, q2} * 10'd10);

  assign p3 = {20'd0, q2_q} * 27'd6554;
  assign q3 = p3[19:16];
  assign r2 = q2_q - ({3'd0, q3} * 7'd10);

  always_comb begin
    case (t2_q.rank)
      2'd0:    digit = d0_2_q;
      2'd1:    digit = d1_q;
      2'd2:    digit = r2[3:0];
      default: digit = q3;
    endcase
    case (t2_q.sym)
      SYM_DIGIT: seg = seg_of_digit(digit);
      SYM_MINUS: seg = SEG_MINUS;
      SYM_E:     seg = SEG_E;
      default:   seg = SEG_R;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      t1_q <= token_i;
      q1_q <= q1;
      d0_q <= r0[3:0];
    end
    if (en2) begin
      t2_q   <= t1_q;
      q2_q   <= q2;
      d0_2_q <= d0_q;
      d1_q   <= r1[3:0];
    end
    if (en3) begin
      out_o.digit_enable <= 4'd1 << t2_q.rank;
      out_o.segments     <= seg;
      out_o.frame_end    <= t2_q.frame_end;
    end
  end

  assign out_o.valid = v3_q;

endmodule

[sv/seven_segment_number_scanner.sv]
// Multiplexed four-digit seven-segment scanner. Every input beat is one
// display time slot and yields exactly one output beat: a one-hot digit
// enable (rank 3 leftmost), its segment pattern (bit 0 = a .. bit 6 = g)
// and a frame_end flag on the last slot of a frame. The value is sampled
// only on the first slot of a frame; 0..9999 scans ranks 0..3 with leading
// zeros, -999..-1 alternates a minus on rank 3 with magnitude ranks 0..2,
// above 9999 shows "Err", below -999 shows "-Err" once. frame_repeats sets
// the rounds per frame (0 acts as 1) and is read live. Sustained rate is one
// slot per clock as long as the sink does not stall. Each beat passes
// through the queue, then two decimal split stages in the back end, and
// lands in the segment encoder's output register, from which it is handed
// over once the sink is ready. No clearing pass is needed after reset.
module seven_segment_number_scanner import scn_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  scn_in_if.sink     in_i,
  scn_out_if.source  out_o
);

  logic [7:0] frame_repeats_q;

  logic       push, pop, full, q_valid;
  scn_token_t push_token, pop_token;

  // frame_repeats register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_repeats_q <= REPEATS_RESET;
    end else if (cfg_we_i) begin
      frame_repeats_q <= cfg_data_i;
    end
  end

  // front end: frame/round/slot tracking, picks rank and symbol
  scn_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_repeats_i (frame_repeats_q),
    .in_i            (in_i),
    .full_i          (full),
    .push_o          (push),
    .token_o         (push_token)
  );

  // short queue decouples the two sides
  scn_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_token),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_token)
  );

  // back end: decimal split, segment encode, output register
  scn_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .token_i (pop_token),
    .pop_o   (pop),
    .out_o   (out_o)
  );

`ifndef NO_ASSERTIONS
  a_onehot_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> $onehot(out_o.digit_enable))
    else $error("digit enable not one-hot");
  a_lit_segments: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.segments != 7'd0)
    else $error("blank slot");
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> frame_repeats_q == $past(cfg_data_i))
    else $error("frame_repeats write lost");
`endif

endmodule

[bench/seven_segment_number_scanner_tb.sv]
`timescale 1ns / 100ps

module seven_segment_number_scanner_tb;
  import scn_pkg::*;

  // watchdog, far above the slowest legal run of ~850 slots
  localparam int CycleLimit = 300000;

  // digit glyphs 9..0, seven bits each, a in bit 0
  localparam logic [69:0] DigitGlyphs = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  typedef struct packed {
    logic [3:0] digit_enable;
    logic [6:0] segments;
    logic       frame_end;
  } slot_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;

  scn_in_if  slot_in ();
  scn_out_if slot_out ();

  seven_segment_number_scanner i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (slot_in),
    .out_o      (slot_out)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // scanner shadow state
  logic [7:0] repeats_cfg;
  logic [1:0] shadow_mode;
  logic [3:0] shadow_digits [4];
  logic [2:0] shadow_slot;
  logic [7:0] shadow_round;
  logic       shadow_active;

  slot_beat_t expected_slots [$];

  int error_count    = 0;
  int cycle_count    = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Works out the beat for one accepted slot and advances the shadow state.
  task automatic predict_slot(input logic signed [31:0] v);
    slot_beat_t beat;
    logic [1:0] rank;
    logic [6:0] seg;
    int         slot_count;
    int         rounds;
    int         mag;
    logic       last_slot;
    logic       last_round;
    // first slot of a frame: latch and split the value
    if (!shadow_active) begin
      foreach (shadow_digits[k]) shadow_digits[k] = 4'd0;
      if (v > VALUE_MAX) begin
        shadow_mode = MODE_OVF;
      end else if (v < VALUE_MIN) begin
        shadow_mode = MODE_UNF;
      end else begin
        shadow_mode = (v < 0) ? MODE_NEG : MODE_NUM;
        mag = (v < 0) ? -v : v;
        shadow_digits[0] = 4'(mag % 10);
        shadow_digits[1] = 4'((mag % 100) / 10);
        shadow_digits[2] = 4'((mag % 1000) / 100);
        shadow_digits[3] = 4'(mag / 1000);
      end
      shadow_slot   = 3'd0;
      shadow_round  = 8'd0;
      shadow_active = 1'b1;
    end
    case (shadow_mode)
      MODE_NUM: begin
        slot_count = 1;
        rank = shadow_round[1:0];
        seg = DigitGlyphs[shadow_digits[rank]*7 +: 7];
      end
      MODE_NEG: begin
        slot_count = 2;
        if (shadow_slot == 3'd0) begin
          rank = 2'd3;
          seg = SEG_MINUS;
        end else begin
          rank = 2'(shadow_round % 8'd3);
          seg = DigitGlyphs[shadow_digits[rank]*7 +: 7];
        end
      end
      MODE_OVF: begin
        // E r r on ranks 2..0
        slot_count = 3;
        rank = 2'(2 - int'(shadow_slot));
        seg = (rank == 2'd2) ? SEG_E : SEG_R;
      end
      default: begin
        // - E r r on ranks 3..0, a single round
        slot_count = 4;
        rank = 2'(3 - int'(shadow_slot));
        seg = (rank == 2'd3) ? SEG_MINUS : (rank == 2'd2) ? SEG_E : SEG_R;
      end
    endcase
    // zero repeats behaves as one; the register is read live
    rounds = (repeats_cfg == 8'd0) ? 1 : int'(repeats_cfg);
    if (shadow_mode == MODE_UNF) rounds = 1;
    last_slot  = (int'(shadow_slot) + 1 >= slot_count);
    last_round = (int'(shadow_round) + 1 >= rounds);

    beat.digit_enable = 4'b0001 << rank;
    beat.segments     = seg;
    beat.frame_end    = last_slot && last_round;
    expected_slots.push_back(beat);

    if (last_slot) begin
      shadow_slot = 3'd0;
      if (last_round) begin
        shadow_active = 1'b0;
        shadow_round  = 8'd0;
      end else begin
        shadow_round = shadow_round + 8'd1;
      end
    end else begin
      shadow_slot = shadow_slot + 3'd1;
    end
  endtask

  // One input beat. Optional idle gap first; valid is left high on return so
  // that back-to-back beats never drop it.
  task automatic send_slot(input logic signed [31:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      slot_in.valid <= 1'b0;
    end
    @(negedge clk_i);
    slot_in.valid <= 1'b1;
    slot_in.value <= v;
    do @(posedge clk_i); while (!slot_in.ready);
    predict_slot(v);
  endtask

  // A frame's first value followed by filler the block must ignore.
  task automatic send_frame(input logic signed [31:0] v, input int n_slots);
    send_slot(v);
    repeat (n_slots - 1) send_slot($urandom);
  endtask

  // Stops the sender and holds off until every beat has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    slot_in.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_repeats(input logic [7:0] r);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= r;
    @(posedge clk_i);
    repeats_cfg = r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_value();
    int r;
    int m;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(9999);
    if (r < 65) begin
      m = $urandom_range(999, 1);
      return -m;
    end
    if (r < 75) return $urandom_range(32'h7FFF_FFFF, 10000);
    if (r < 85) begin
      m = $urandom_range(32'h7FFF_FFFF, 1000);
      return -m;
    end
    if (r < 92) return $urandom;
    case ($urandom_range(7))
      0: return 32'sd0;
      1: return 32'sd9999;
      2: return 32'sd10000;
      3: return -32'sd1;
      4: return -32'sd999;
      5: return -32'sd1000;
      6: return 32'sh7FFF_FFFF;
      default: return 32'sh8000_0000;
    endcase
  endfunction

  function automatic logic [7:0] pick_repeats();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    if (r < 50) return 8'd1;
    if (r < 85) return 8'($urandom_range(4, 2));
    return 8'($urandom_range(254, 5));
  endfunction

  // Reset value of the register, then zero acting as one, changed mid-frame.
  task automatic test_reset_repeats();
    send_frame(32'sd9876, 5);  // ranks 0,1,2,3,0, no frame end at 16 rounds
    wait_drained();
    write_repeats(8'd0);
    send_slot($urandom);       // rank 1 closes the frame
    wait_drained();
  endtask

  // Every frame mode and the range edges, one round per frame.
  task automatic test_frame_modes();
    write_repeats(8'd1);
    send_frame(32'sd0, 1);
    send_frame(32'sd9999, 1);
    send_frame(32'sd1234, 1);
    send_frame(32'sd5678, 1);
    send_frame(-32'sd1, 2);
    send_frame(-32'sd999, 2);
    send_frame(32'sd10000, 3);
    send_frame(32'sh7FFF_FFFF, 3);
    send_frame(-32'sd1000, 4);
    send_frame(32'sh8000_0000, 4);
    wait_drained();
  endtask

  // Full eight-bit round count, and a long negative frame cut short live.
  task automatic test_full_round_count();
    write_repeats(8'd255);
    send_frame(32'sd8642, 255);
    send_frame(-32'sd123, 40);
    wait_drained();
    write_repeats(8'd2);       // round 20 now closes the frame
    send_slot($urandom);
    send_slot($urandom);
    wait_drained();
  endtask

  // Random values and repeat counts under one idling pattern. Each register
  // change waits for the scanner to empty first.
  task automatic test_random_slots(input int n_slots, input int src_pct,
                                   input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int i = 0; i < n_slots; i++) begin
      if (i % 40 == 0) begin
        wait_drained();
        write_repeats(pick_repeats());
      end
      send_slot(pick_value());
    end
    wait_drained();
  endtask

  // sink side: random back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    slot_out.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // compare each output beat with the oldest prediction
  always @(posedge clk_i) begin
    slot_beat_t want;
    if (rst_ni && slot_out.valid && slot_out.ready) begin
      if (expected_slots.size() == 0) begin
        flag_mismatch($sformatf("beat with nothing pending: en=%b seg=%h end=%b",
                                slot_out.digit_enable, slot_out.segments,
                                slot_out.frame_end));
      end else begin
        want = expected_slots.pop_front();
        if (slot_out.digit_enable !== want.digit_enable)
          flag_mismatch($sformatf("digit_enable %b, want %b",
                                  slot_out.digit_enable, want.digit_enable));
        if (slot_out.segments !== want.segments)
          flag_mismatch($sformatf("segments %h, want %h",
                                  slot_out.segments, want.segments));
        if (slot_out.frame_end !== want.frame_end)
          flag_mismatch($sformatf("frame_end %b, want %b",
                                  slot_out.frame_end, want.frame_end));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[seven_segment_number_scanner] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_data_i     = 8'd0;
    slot_in.valid  = 1'b0;
    slot_in.value  = 32'sd0;
    slot_out.ready = 1'b0;
    repeats_cfg    = REPEATS_RESET;
    shadow_mode    = MODE_NUM;
    foreach (shadow_digits[k]) shadow_digits[k] = 4'd0;
    shadow_slot    = 3'd0;
    shadow_round   = 8'd0;
    shadow_active  = 1'b0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_repeats();
    test_frame_modes();
    test_full_round_count();
    test_random_slots(130, 0, 0);
    test_random_slots(130, 60, 0);
    test_random_slots(130, 0, 60);
    test_random_slots(130, 27, 27);

    // settle past the pipeline before the verdict
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[seven_segment_number_scanner] OK");
    end else begin
      $display("[seven_segment_number_scanner] ERROR");
    end
    $finish;
  end

endmodule
